FILE: src/sefc_pkg.sv
// sefc_pkg: shared types, constants and the hex decode for the frame checker
// no dependencies; imported by stx_etx_frame_checker_unit
package sefc_pkg;

   localparam logic [7:0] FRAME_START   = 8'h01;
   localparam logic [7:0] FRAME_END     = 8'h04;
   localparam logic [8:0] FRAME_MIN_LEN = 9'd6;
   localparam logic [8:0] COUNT_SAT     = 9'd511;

   localparam logic [2:0] ERR_OK        = 3'd0;
   localparam logic [2:0] ERR_SHORT     = 3'd1;
   localparam logic [2:0] ERR_START     = 3'd2;
   localparam logic [2:0] ERR_END       = 3'd3;
   localparam logic [2:0] ERR_CHECKSUM  = 3'd4;
   localparam logic [2:0] ERR_LONG      = 3'd5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic       frame_ok;
      logic [2:0] error_code;
      logic [7:0] packet_type;
   } rsp_payload_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] nibble;
   } hex_digit_type;

   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type d;
      d.valid  = 1'b1;
      d.nibble = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.nibble = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d.nibble = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d.nibble = 4'(c - 8'h57);
      end else begin
         d.valid  = 1'b0;
      end
      return d;
   endfunction

endpackage

FILE: src/stx_etx_frame_checker_unit.sv
// result: registered, so it reaches rsp in the cycle after the transfer of a frame's last byte
// throughput: one byte per cycle unless a held result stalls req_ready; the per-frame state and
// the result register update in the same cycle, and the result register frees while being read
// reset: synchronous, active high; clears the frame state and drops rsp_valid
// stx_etx_frame_checker_unit: top level, byte-serial frame check; uses sefc_pkg
module stx_etx_frame_checker_unit
   import sefc_pkg::*;
#(
   parameter int MAX_FRAME_LEN = 255
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam logic [8:0] MAX_LEN = 9'(MAX_FRAME_LEN);

   logic [8:0]      byte_count_ff, byte_count_in;
   logic [7:0]      running_xor_ff, running_xor_in;
   logic [7:0]      held_old_ff, held_old_in;
   logic [7:0]      held_new_ff, held_new_in;
   logic            start_ok_ff, start_ok_in;
   logic [7:0]      type_high_ff, type_high_in;
   logic [7:0]      type_low_ff, type_low_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic            req_fire;
   logic [7:0]      b;
   logic            last;
   hex_digit_type   sum_hi, sum_lo, typ_hi, typ_lo;
   logic [2:0]      code;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign req_fire    = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign b           = req_payload.data_byte;
   assign last        = req_payload.last_byte;

   always_comb begin
      // bytes taken in this same transfer count too
      start_ok_in  = (byte_count_ff == 9'd0) ? (b == FRAME_START) : start_ok_ff;
      type_high_in = (byte_count_ff == 9'd1) ? b : type_high_ff;
      type_low_in  = (byte_count_ff == 9'd2) ? b : type_low_ff;

      sum_hi = hex_decode(held_old_ff);
      sum_lo = hex_decode(held_new_ff);
      typ_hi = hex_decode(type_high_in);
      typ_lo = hex_decode(type_low_in);

      if (byte_count_ff < FRAME_MIN_LEN - 9'd1) begin
         code = ERR_SHORT;
      end else if (byte_count_ff >= MAX_LEN) begin
         code = ERR_LONG;
      end else if (!start_ok_in) begin
         code = ERR_START;
      end else if (b != FRAME_END) begin
         code = ERR_END;
      end else if (!sum_hi.valid || !sum_lo.valid ||
                   {sum_hi.nibble, sum_lo.nibble} != running_xor_ff) begin
         code = ERR_CHECKSUM;
      end else begin
         code = ERR_OK;
      end

      rsp_payload_in.frame_ok    = (code == ERR_OK);
      rsp_payload_in.error_code  = code;
      rsp_payload_in.packet_type = {typ_hi.valid ? typ_hi.nibble : 4'd0,
                                    typ_lo.valid ? typ_lo.nibble : 4'd0};

      byte_count_in  = byte_count_ff;
      running_xor_in = running_xor_ff;
      held_old_in    = held_old_ff;
      held_new_in    = held_new_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      if (req_fire) begin
         if (last) begin
            byte_count_in  = 9'd0;
            running_xor_in = 8'd0;
            held_old_in    = 8'd0;
            held_new_in    = 8'd0;
            start_ok_in    = 1'b0;
            type_high_in   = 8'd0;
            type_low_in    = 8'd0;
            rsp_valid_in   = 1'b1;
         end else begin
            // the xor trails the input by two bytes
            if (byte_count_ff >= 9'd2) begin
               running_xor_in = running_xor_ff ^ held_old_ff;
            end
            held_old_in = held_new_ff;
            held_new_in = b;
            if (byte_count_ff != COUNT_SAT) begin
               byte_count_in = byte_count_ff + 9'd1;
            end
         end
      end else begin
         start_ok_in  = start_ok_ff;
         type_high_in = type_high_ff;
         type_low_in  = type_low_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= 9'd0;
         running_xor_ff <= 8'd0;
         held_old_ff    <= 8'd0;
         held_new_ff    <= 8'd0;
         start_ok_ff    <= 1'b0;
         type_high_ff   <= 8'd0;
         type_low_ff    <= 8'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         byte_count_ff  <= byte_count_in;
         running_xor_ff <= running_xor_in;
         held_old_ff    <= held_old_in;
         held_new_ff    <= held_new_in;
         start_ok_ff    <= start_ok_in;
         type_high_ff   <= type_high_in;
         type_low_ff    <= type_low_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && last) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire && last |=> rsp_valid_ff && byte_count_ff == 9'd0)
      else $error("last byte transfer did not yield a result and clear the frame");

   a_ok_matches_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_payload_ff.frame_ok == (rsp_payload_ff.error_code == ERR_OK))
      else $error("frame_ok disagrees with error_code");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_payload_ff.error_code <= ERR_LONG)
      else $error("error_code out of range");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      req_fire && !last && byte_count_ff != COUNT_SAT
      |=> byte_count_ff == $past(byte_count_ff) + 9'd1)
      else $error("byte count did not advance");

   a_idle_holds_state: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(byte_count_ff) && $stable(running_xor_ff))
      else $error("frame state changed without a transfer");

endmodule

FILE: verif/testbench.sv
// testbench for stx_etx_frame_checker_unit: drives framed byte streams and
// checks each frame verdict against a cycle-free model of the checks
// depends on sefc_pkg for the payload types, frame constants and error codes
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sefc_pkg::*;

   localparam int MAX_LEN      = 255;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 2000;
   localparam int PRESS_FRAMES = 20;
   localparam int RANDOM_BYTES = 260;
   localparam int TAIL_BYTES   = 100;

   typedef enum int {
      FRM_GOOD, FRM_BAD_START, FRM_BAD_END, FRM_BAD_SUM,
      FRM_HEX_SUM, FRM_HEX_TYPE, FRM_SHORT, FRM_NOISE
   } frame_kind_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   stx_etx_frame_checker_unit #(.MAX_FRAME_LEN(MAX_LEN)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #6 clock = ~clock;

   // model state for the frame in progress
   int unsigned fr_count = 0;
   logic [7:0]  fr_xor = '0;
   logic [7:0]  fr_held [2] = '{8'h00, 8'h00};
   logic        fr_start_ok = 1'b0;
   logic [7:0]  fr_type_hi = '0;
   logic [7:0]  fr_type_lo = '0;

   rsp_payload_type expected_verdicts[$];
   logic [7:0]      frame_buf[$];

   bit gaps_on  = 1'b1;
   bit hold_rsp = 1'b0;
   int fail_count     = 0;
   int stall_cycles   = 0;
   int bytes_sent     = 0;
   int frames_checked = 0;
   int frames_good    = 0;

   // -1 for anything that is not a hex digit
   function automatic int char_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      return -1;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
   endfunction

   function automatic logic [7:0] rand_non_hex();
      logic [7:0] c;
      do c = 8'($urandom); while (char_value(c) >= 0);
      return c;
   endfunction

   function automatic void predict_frame_byte(input req_payload_type p);
      int unsigned     k;
      int              len, hi, lo, th, tl;
      rsp_payload_type v;
      k = fr_count;
      if (k == 0) fr_start_ok = (p.data_byte == FRAME_START);
      if (k == 1) fr_type_hi = p.data_byte;
      if (k == 2) fr_type_lo = p.data_byte;
      if (!p.last_byte) begin
         // xor trails by two bytes so the checksum characters stay out of it
         if (k >= 2) fr_xor ^= fr_held[0];
         fr_held[0] = fr_held[1];
         fr_held[1] = p.data_byte;
         if (fr_count < COUNT_SAT) fr_count++;
         return;
      end
      len = int'(k) + 1;
      hi = char_value(fr_held[0]);
      lo = char_value(fr_held[1]);
      if (len < int'(FRAME_MIN_LEN)) begin
         v.error_code = ERR_SHORT;
      end else if (len > MAX_LEN) begin
         v.error_code = ERR_LONG;
      end else if (!fr_start_ok) begin
         v.error_code = ERR_START;
      end else if (p.data_byte != FRAME_END) begin
         v.error_code = ERR_END;
      end else if (hi < 0 || lo < 0 || 8'((hi << 4) | lo) != fr_xor) begin
         v.error_code = ERR_CHECKSUM;
      end else begin
         v.error_code = ERR_OK;
      end
      v.frame_ok = (v.error_code == ERR_OK);
      th = char_value(fr_type_hi);
      tl = char_value(fr_type_lo);
      if (th < 0) th = 0;
      if (tl < 0) tl = 0;
      v.packet_type = 8'((th << 4) | tl);
      expected_verdicts.push_back(v);
      fr_count    = 0;
      fr_xor      = '0;
      fr_held[0]  = '0;
      fr_held[1]  = '0;
      fr_start_ok = 1'b0;
      fr_type_hi  = '0;
      fr_type_lo  = '0;
   endfunction

   // sample both channels at the rising edge, inputs only move on the falling edge
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset) begin
         if (req_valid && req_ready) predict_frame_byte(req_payload);
         if (rsp_valid && rsp_ready) begin
            frames_checked++;
            if (expected_verdicts.size() == 0) begin
               $display("%0t: verdict with none expected, got ok=%0b code=%0d type=%02h",
                        $time, rsp_payload.frame_ok, rsp_payload.error_code,
                        rsp_payload.packet_type);
               fail_count++;
            end else begin
               want = expected_verdicts.pop_front();
               if (want.frame_ok) frames_good++;
               if (rsp_payload.frame_ok !== want.frame_ok) begin
                  $display("%0t: frame_ok expected %0b, got %0b",
                           $time, want.frame_ok, rsp_payload.frame_ok);
                  fail_count++;
               end
               if (rsp_payload.error_code !== want.error_code) begin
                  $display("%0t: error_code expected %0d, got %0d",
                           $time, want.error_code, rsp_payload.error_code);
                  fail_count++;
               end
               if (rsp_payload.packet_type !== want.packet_type) begin
                  $display("%0t: packet_type expected %02h, got %02h",
                           $time, want.packet_type, rsp_payload.packet_type);
                  fail_count++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
         else stall_cycles++;
      end
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // result side: random ready bursts, plus one long hold on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 10)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      req_payload_type p;
      p.data_byte = b;
      p.last_byte = last;
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 10)) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_buf.size(); i++) begin
         send_byte(frame_buf[i], i == frame_buf.size() - 1);
      end
   endtask

   task automatic build_frame(input frame_kind_type kind, input int body_len,
                              input logic [7:0] ptype, input bit lower);
      logic [7:0] sum, t_hi, t_lo, c;
      int         n;
      frame_buf.delete();
      if (kind == FRM_SHORT || kind == FRM_NOISE) begin
         n = (kind == FRM_SHORT) ? $urandom_range(1, 5) : $urandom_range(6, 24);
         repeat (n) frame_buf.push_back(8'($urandom));
         if (kind == FRM_SHORT && $urandom_range(0, 1)) begin
            frame_buf[0] = FRAME_START;
            frame_buf[frame_buf.size() - 1] = FRAME_END;
         end
         return;
      end
      t_hi = hex_char(ptype[7:4], lower);
      t_lo = hex_char(ptype[3:0], lower);
      if (kind == FRM_HEX_TYPE) begin
         if ($urandom_range(0, 1)) t_hi = rand_non_hex();
         else t_lo = rand_non_hex();
      end
      frame_buf.push_back(FRAME_START);
      frame_buf.push_back(t_hi);
      frame_buf.push_back(t_lo);
      repeat (body_len) frame_buf.push_back(8'($urandom));
      sum = '0;
      foreach (frame_buf[i]) sum ^= frame_buf[i];
      if (kind == FRM_BAD_SUM) sum ^= 8'($urandom_range(1, 255));
      frame_buf.push_back(hex_char(sum[7:4], lower));
      frame_buf.push_back(hex_char(sum[3:0], lower));
      frame_buf.push_back(FRAME_END);
      case (kind)
         FRM_BAD_START: begin
            do c = 8'($urandom); while (c == FRAME_START);
            frame_buf[0] = c;
         end
         FRM_BAD_END: begin
            do c = 8'($urandom); while (c == FRAME_END);
            frame_buf[frame_buf.size() - 1] = c;
         end
         FRM_HEX_SUM: begin
            frame_buf[frame_buf.size() - 2 - $urandom_range(0, 1)] = rand_non_hex();
         end
         default: ;
      endcase
   endtask

   task automatic test_directed();
      build_frame(FRM_GOOD, 0, 8'h00, 1'b0);
      send_frame();
      build_frame(FRM_GOOD, 0, 8'hFF, 1'b1);
      send_frame();
      build_frame(FRM_GOOD, 2, 8'hA5, 1'b0);
      send_frame();
      // a frame that is nothing but its last byte
      frame_buf.delete();
      frame_buf.push_back(FRAME_END);
      send_frame();
      build_frame(FRM_SHORT, 0, 8'h00, 1'b0);
      send_frame();
      build_frame(FRM_BAD_START, 0, 8'($urandom), 1'b0);
      send_frame();
      build_frame(FRM_BAD_END, 0, 8'($urandom), 1'b1);
      send_frame();
      build_frame(FRM_BAD_SUM, 0, 8'($urandom), 1'b0);
      send_frame();
      build_frame(FRM_HEX_SUM, 0, 8'($urandom), 1'b1);
      send_frame();
      build_frame(FRM_HEX_TYPE, 0, 8'($urandom), 1'b0);
      send_frame();
   endtask

   task automatic test_length_limits();
      // longest legal frame, one past it, then long enough to saturate the count
      build_frame(FRM_GOOD, MAX_LEN - 6, 8'h3C, 1'b1);
      send_frame();
      build_frame(FRM_GOOD, MAX_LEN - 5, 8'h3C, 1'b0);
      send_frame();
      build_frame(FRM_GOOD, 600 - 6, 8'hC3, 1'b0);
      send_frame();
      build_frame(FRM_GOOD, 0, 8'h5A, 1'b1);
      send_frame();
   endtask

   task automatic test_backpressure();
      gaps_on  = 1'b0;
      hold_rsp = 1'b1;
      repeat (PRESS_FRAMES) begin
         build_frame(FRM_GOOD, 0, 8'($urandom), $urandom_range(0, 1));
         send_frame();
      end
   endtask

   task automatic test_random_frames(input int budget);
      int             goal, r, body;
      frame_kind_type kind;
      goal = bytes_sent + budget;
      while (bytes_sent < goal) begin
         r = $urandom_range(0, 99);
         if (r < 65) kind = FRM_GOOD;
         else if (r < 70) kind = FRM_BAD_START;
         else if (r < 75) kind = FRM_BAD_END;
         else if (r < 81) kind = FRM_BAD_SUM;
         else if (r < 86) kind = FRM_HEX_SUM;
         else if (r < 91) kind = FRM_HEX_TYPE;
         else if (r < 96) kind = FRM_SHORT;
         else kind = FRM_NOISE;
         body = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 9);
         build_frame(kind, body, 8'($urandom), $urandom_range(0, 1));
         send_frame();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_length_limits();
      test_backpressure();
      gaps_on = 1'b1;
      test_random_frames(RANDOM_BYTES);
      gaps_on = 1'b0;
      test_random_frames(TAIL_BYTES);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      $display("run covered %0d bytes in %0d frames: %0d passed the frame checks, %0d rejected",
               bytes_sent, frames_checked, frames_good, frames_checked - frames_good);
      $display("mix: all error codes, both hex cases, length limits and a long result stall");
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: stx_etx_frame_checker_unit.f
src/sefc_pkg.sv
src/stx_etx_frame_checker_unit.sv
verif/testbench.sv
